>>> hw/rtl/tse_pkg.sv
// shared types and constants for the tls server-name extractor
package tse_pkg;

  localparam int unsigned MAX_PAYLOAD = 65536;
  localparam int unsigned POS_W       = 18;
  localparam int unsigned FIFO_DEPTH  = 4;
  localparam int unsigned FIFO_AW     = $clog2(FIFO_DEPTH);

  localparam logic [7:0]  HS_RECORD    = 8'h16;
  localparam logic [7:0]  CLIENT_HELLO = 8'h01;
  localparam logic [POS_W-1:0] FIXED_SKIP = POS_W'(43);
  localparam logic [15:0] SNI_TYPE     = 16'h0000;

  localparam logic       KIND_NAME    = 1'b0;
  localparam logic       KIND_VERDICT = 1'b1;

  localparam logic [1:0] ST_NONE      = 2'd0;
  localparam logic [1:0] ST_FOUND     = 2'd1;
  localparam logic [1:0] ST_TRUNC     = 2'd2;

  localparam logic [1:0] SD_SEARCH    = 2'd0;
  localparam logic [1:0] SD_NONE      = 2'd1;
  localparam logic [1:0] SD_FOUND     = 2'd2;

  typedef struct packed {
    logic        kind;
    logic [7:0]  name_byte;
    logic [1:0]  status;
    logic [15:0] name_length;
    logic        last_result;
  } result_t;

endpackage

>>> hw/rtl/tse_byte_if.sv
// payload byte channel
interface tse_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> hw/rtl/tse_result_if.sv
// server name result channel
interface tse_result_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  name_byte;
  logic [1:0]  status;
  logic [15:0] name_length;
  logic        last_result;

  modport source (output valid, output kind, output name_byte, output status,
                  output name_length, output last_result, input ready);
  modport sink   (input valid, input kind, input name_byte, input status,
                  input name_length, input last_result, output ready);
endinterface

>>> hw/rtl/tls_sni_extractor_core.sv
// tls client hello server-name extractor, one payload byte per cycle unless stalled
//
//   channel   dir  payload                                          notes
//   bytes     in   data_byte, last_byte                             one tcp payload byte
//   results   out  kind, name_byte, status, name_length, last_result name bytes, then verdict
//
// one byte parsed per cycle unless stalled; state updates in the cycle the byte is taken
// results go into a 4-entry queue; a byte may add two (name byte plus verdict)
// bytes is ready while the queue has at least two free slots, so stalls come only from results
// synchronous rst clears the parser and empties the queue; no clearing pass
module tls_sni_extractor_core
  import tse_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  tse_byte_if.sink     bytes,
  tse_result_if.source results
);

  localparam logic [3:0] PH_SID   = 4'd0;
  localparam logic [3:0] PH_CS_HI = 4'd1;
  localparam logic [3:0] PH_CS_LO = 4'd2;
  localparam logic [3:0] PH_CM    = 4'd3;
  localparam logic [3:0] PH_EL_HI = 4'd4;
  localparam logic [3:0] PH_EL_LO = 4'd5;
  localparam logic [3:0] PH_XT_HI = 4'd6;
  localparam logic [3:0] PH_XT_LO = 4'd7;
  localparam logic [3:0] PH_XL_HI = 4'd8;
  localparam logic [3:0] PH_XL_LO = 4'd9;
  localparam logic [3:0] PH_SN0   = 4'd10;
  localparam logic [3:0] PH_SN1   = 4'd11;
  localparam logic [3:0] PH_SN2   = 4'd12;
  localparam logic [3:0] PH_SN3   = 4'd13;
  localparam logic [3:0] PH_SN4   = 4'd14;
  localparam logic [3:0] PH_NAME  = 4'd15;

  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_PAYLOAD);
  localparam int unsigned CNT_W = FIFO_AW + 1;

  // parser state
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [3:0]       parse_phase, parse_phase_next;
  logic [7:0]       field_accumulator, field_accumulator_next;
  logic [POS_W-1:0] next_field_position, next_field_position_next;
  logic [POS_W-1:0] extensions_end, extensions_end_next;
  logic [15:0]      extension_type_hold, extension_type_hold_next;
  logic [15:0]      name_remaining, name_remaining_next;
  logic [15:0]      name_total, name_total_next;
  logic [1:0]       search_done, search_done_next;

  // result queue
  result_t            fifo [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;

  logic       in_fire, out_fire;
  logic       emit;
  logic [7:0] b;
  logic [POS_W:0] pos_x, len_end, tgt_x, xend_x;
  logic [15:0]    len;
  logic           do_goto;
  logic [POS_W-1:0] goto_tgt, xend_eff;
  logic [1:0]     push_n;
  result_t        name_item, verdict_item;

  assign b        = bytes.data_byte;
  assign in_fire  = bytes.valid && bytes.ready;
  assign out_fire = results.valid && results.ready;
  assign bytes.ready = (count <= CNT_W'(FIFO_DEPTH - 2));

  assign pos_x   = {1'b0, byte_position};
  assign len     = {field_accumulator, b};
  assign len_end = pos_x + (POS_W+1)'(1) + (POS_W+1)'(len);

  always_comb begin
    byte_position_next       = byte_position;
    parse_phase_next         = parse_phase;
    field_accumulator_next   = field_accumulator;
    next_field_position_next = next_field_position;
    extensions_end_next      = extensions_end;
    extension_type_hold_next = extension_type_hold;
    name_remaining_next      = name_remaining;
    name_total_next          = name_total;
    search_done_next         = search_done;
    emit     = 1'b0;
    do_goto  = 1'b0;
    goto_tgt = '0;
    xend_eff = extensions_end;
    tgt_x    = '0;
    xend_x   = '0;

    if (in_fire && byte_position < POS_LIMIT) begin
      byte_position_next = byte_position + POS_W'(1);
      if (search_done == SD_SEARCH) begin
        if (parse_phase == PH_NAME) begin
          name_remaining_next = name_remaining - 16'd1;
          if (name_remaining == 16'd1) begin
            search_done_next = SD_FOUND;
          end
          emit = 1'b1;
        end else if (parse_phase == PH_SID &&
                     ((byte_position == '0 && b != HS_RECORD) ||
                      (byte_position == POS_W'(5) && b != CLIENT_HELLO))) begin
          search_done_next = SD_NONE;
        end else if (byte_position == next_field_position) begin
          case (parse_phase)
            PH_SID, PH_CM: begin
              next_field_position_next = byte_position + POS_W'(1) + POS_W'(b);
              parse_phase_next = parse_phase + 4'd1;
            end
            PH_CS_LO: begin
              next_field_position_next = len_end[POS_W-1:0];
              parse_phase_next = PH_CM;
            end
            PH_EL_LO: begin
              extensions_end_next = len_end[POS_W-1:0];
              xend_eff = len_end[POS_W-1:0];
              do_goto  = 1'b1;
              goto_tgt = byte_position + POS_W'(1);
            end
            PH_XT_LO: begin
              extension_type_hold_next = len;
              next_field_position_next = byte_position + POS_W'(1);
              parse_phase_next = PH_XL_HI;
            end
            PH_XL_LO: begin
              if (extension_type_hold == SNI_TYPE &&
                  pos_x + (POS_W+1)'(5) < {1'b0, extensions_end}) begin
                // extension length kept for a skip past a non-matching entry
                name_total_next = len;
                next_field_position_next = byte_position + POS_W'(1);
                parse_phase_next = PH_SN0;
              end else begin
                do_goto  = 1'b1;
                goto_tgt = len_end[POS_W-1:0];
              end
            end
            PH_SN2: begin
              extension_type_hold_next = {8'd0, b};
              next_field_position_next = byte_position + POS_W'(1);
              parse_phase_next = PH_SN3;
            end
            PH_SN4: begin
              if (extension_type_hold == 16'd0 && len_end <= {1'b0, extensions_end}) begin
                if (len == 16'd0) begin
                  search_done_next = SD_NONE;
                end else begin
                  name_remaining_next = len;
                  name_total_next     = len;
                  parse_phase_next    = PH_NAME;
                end
              end else if (name_total < 16'd5) begin
                search_done_next = SD_NONE;
              end else begin
                // back to the start of this extension's body, then past it
                tgt_x    = pos_x - (POS_W+1)'(4) + (POS_W+1)'(name_total);
                do_goto  = 1'b1;
                goto_tgt = tgt_x[POS_W-1:0];
              end
            end
            default: begin
              field_accumulator_next   = b;
              next_field_position_next = byte_position + POS_W'(1);
              parse_phase_next = parse_phase + 4'd1;
            end
          endcase
          if (do_goto) begin
            next_field_position_next = goto_tgt;
            parse_phase_next = PH_XT_HI;
            xend_x = {1'b0, goto_tgt} + (POS_W+1)'(3);
            if (xend_x >= {1'b0, xend_eff}) begin
              search_done_next = SD_NONE;
            end
          end
        end
      end
    end

    // verdict from the state after this byte
    verdict_item.kind        = KIND_VERDICT;
    verdict_item.name_byte   = 8'd0;
    verdict_item.status      = ST_NONE;
    verdict_item.name_length = 16'd0;
    verdict_item.last_result = 1'b1;
    if (search_done_next == SD_FOUND) begin
      verdict_item.status      = ST_FOUND;
      verdict_item.name_length = name_total_next;
    end else if (search_done_next == SD_SEARCH && parse_phase_next == PH_NAME) begin
      verdict_item.status = ST_TRUNC;
    end

    if (in_fire && bytes.last_byte) begin
      byte_position_next       = '0;
      parse_phase_next         = PH_SID;
      field_accumulator_next   = '0;
      next_field_position_next = FIXED_SKIP;
      extensions_end_next      = '0;
      extension_type_hold_next = '0;
      name_remaining_next      = '0;
      name_total_next          = '0;
      search_done_next         = SD_SEARCH;
    end
  end

  always_comb begin
    name_item.kind        = KIND_NAME;
    name_item.name_byte   = b;
    name_item.status      = ST_NONE;
    name_item.name_length = 16'd0;
    name_item.last_result = 1'b0;
    push_n = 2'(emit) + 2'(in_fire && bytes.last_byte);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position       <= '0;
      parse_phase         <= PH_SID;
      field_accumulator   <= '0;
      next_field_position <= FIXED_SKIP;
      extensions_end      <= '0;
      extension_type_hold <= '0;
      name_remaining      <= '0;
      name_total          <= '0;
      search_done         <= SD_SEARCH;
      wr_ptr              <= '0;
      rd_ptr              <= '0;
      count               <= '0;
    end else begin
      byte_position       <= byte_position_next;
      parse_phase         <= parse_phase_next;
      field_accumulator   <= field_accumulator_next;
      next_field_position <= next_field_position_next;
      extensions_end      <= extensions_end_next;
      extension_type_hold <= extension_type_hold_next;
      name_remaining      <= name_remaining_next;
      name_total          <= name_total_next;
      search_done         <= search_done_next;
      wr_ptr              <= wr_ptr + FIFO_AW'(push_n);
      if (out_fire) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      count <= count + CNT_W'(push_n) - CNT_W'(out_fire);
    end
  end

  // queue storage: name byte first, verdict after it
  always_ff @(posedge clk) begin
    if (emit) begin
      fifo[wr_ptr] <= name_item;
      if (in_fire && bytes.last_byte) begin
        fifo[wr_ptr + FIFO_AW'(1)] <= verdict_item;
      end
    end else if (in_fire && bytes.last_byte) begin
      fifo[wr_ptr] <= verdict_item;
    end
  end

  assign results.valid       = (count != '0);
  assign results.kind        = fifo[rd_ptr].kind;
  assign results.name_byte   = fifo[rd_ptr].name_byte;
  assign results.status      = fifo[rd_ptr].status;
  assign results.name_length = fifo[rd_ptr].name_length;
  assign results.last_result = fifo[rd_ptr].last_result;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_packet_clear: assert property (@(posedge clk) disable iff (rst)
    in_fire && bytes.last_byte |=> byte_position == '0 && search_done == SD_SEARCH)
    else $error("parser not cleared after last byte");

  a_verdict_queued: assert property (@(posedge clk) disable iff (rst)
    in_fire && bytes.last_byte |=> count != '0)
    else $error("verdict not queued");

  a_found_in_name: assert property (@(posedge clk) disable iff (rst)
    search_done == SD_FOUND |-> parse_phase == PH_NAME)
    else $error("name complete outside name phase");

endmodule
